/* src/assert_macros.svh */
// Assertion macros shared by the sorter RTL.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TTS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/tts_pkg.sv */
// Package for the tournament tree sorter: sizes, entry, command and link types.
// Used by tts_cell and tournament_tree_sorter; depends on nothing.
`default_nettype none
package tts_pkg;

  localparam int MAX_ITEMS  = 64;
  localparam int VALUE_BITS = 16;
  localparam int CNT_BITS   = $clog2(MAX_ITEMS + 1);

  typedef struct packed {
    logic                  valid;
    logic [VALUE_BITS-1:0] value;
  } tts_entry_t;

  typedef struct packed {
    logic load;
    logic shift;
  } tts_cmd_t;

  typedef struct packed {
    logic       beaten;
    tts_entry_t entry;
  } tts_link_t;

endpackage
`default_nettype wire

/* src/tts_cell.sv */
// One cell of the sorting chain: holds one entry, kept in descending order.
// Depends on tts_pkg for the entry, link and command types.
`default_nettype none
module tts_cell (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire tts_pkg::tts_cmd_t             cmd,
  input  wire logic [tts_pkg::VALUE_BITS-1:0] new_value,
  input  wire tts_pkg::tts_link_t            left_link,
  input  wire tts_pkg::tts_entry_t           right_entry,
  output tts_pkg::tts_link_t                 link
);
  import tts_pkg::*;

  tts_entry_t entry_r;
  tts_entry_t entry_nxt;
  logic       beaten;

  // An empty cell loses to any new value.
  assign beaten = !entry_r.valid || (new_value > entry_r.value);
  assign link.beaten = beaten;
  assign link.entry  = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (cmd.shift) begin
      entry_nxt = right_entry;
    end else if (cmd.load && beaten) begin
      if (left_link.beaten) begin
        entry_nxt = left_link.entry;
      end else begin
        entry_nxt.valid = 1'b1;
        entry_nxt.value = new_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
    end else begin
      entry_r <= entry_nxt;
    end
  end

endmodule
`default_nettype wire

/* src/tournament_tree_sorter.sv */
// A request is registered into the cell chain; requests load at one per cycle while busy is low and a cell is free.
// The first result appears the cycle after the request marked last, then one result per cycle.
// Busy stays high while the N values of a set are shifted out of the chain, head first.
// The receiver cannot stall; results are never held back.
// Synchronous active-low reset empties every cell and clears the counters.
`default_nettype none
`include "assert_macros.svh"
module tournament_tree_sorter (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [tts_pkg::VALUE_BITS-1:0] in_sample_value,
  input  wire logic                          in_last_of_set,
  output logic                               out_valid,
  output logic [tts_pkg::VALUE_BITS-1:0]     out_sorted_value,
  output logic                               out_last_result
);
  import tts_pkg::*;

  logic                emitting_r, emitting_nxt;
  logic [CNT_BITS-1:0] loaded_count_r, loaded_count_nxt;
  logic [CNT_BITS-1:0] remaining_r, remaining_nxt;
  logic                accept;
  logic                has_room;
  tts_cmd_t            cmd;
  tts_link_t           links [MAX_ITEMS];

  assign accept   = start && !emitting_r;
  assign has_room = loaded_count_r < CNT_BITS'(MAX_ITEMS);
  assign cmd.load  = accept && has_room;
  assign cmd.shift = emitting_r;

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    tts_link_t  left_link;
    tts_entry_t right_entry;
    if (i == 0) begin : g_head
      assign left_link = '0;
    end else begin : g_body
      assign left_link = links[i-1];
    end
    if (i == MAX_ITEMS - 1) begin : g_tail
      assign right_entry = '0;
    end else begin : g_inner
      assign right_entry = links[i+1].entry;
    end
    tts_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .new_value   (in_sample_value),
      .left_link   (left_link),
      .right_entry (right_entry),
      .link        (links[i])
    );
  end

  always_comb begin
    emitting_nxt     = emitting_r;
    loaded_count_nxt = loaded_count_r;
    remaining_nxt    = remaining_r;
    if (emitting_r) begin
      remaining_nxt = remaining_r - CNT_BITS'(1);
      if (remaining_r == CNT_BITS'(1)) begin
        emitting_nxt = 1'b0;
      end
    end else if (accept) begin
      if (in_last_of_set) begin
        emitting_nxt     = 1'b1;
        remaining_nxt    = loaded_count_r + CNT_BITS'(has_room);
        loaded_count_nxt = '0;
      end else begin
        loaded_count_nxt = loaded_count_r + CNT_BITS'(has_room);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emitting_r     <= 1'b0;
      loaded_count_r <= '0;
      remaining_r    <= '0;
    end else begin
      emitting_r     <= emitting_nxt;
      loaded_count_r <= loaded_count_nxt;
      remaining_r    <= remaining_nxt;
    end
  end

  assign busy             = emitting_r;
  assign out_valid        = emitting_r;
  assign out_sorted_value = links[0].entry.value;
  assign out_last_result  = emitting_r && (remaining_r == CNT_BITS'(1));

  `TTS_ASSERT_NOW(a_head_full, out_valid, links[0].entry.valid, "result from an empty head cell")
  `TTS_ASSERT_NEXT(a_run_on, out_valid && !out_last_result, out_valid, "sorted run cut short")
  `TTS_ASSERT_NEXT(a_run_end, out_last_result, !busy && !links[0].entry.valid, "chain not empty")
  `TTS_ASSERT_NOW(a_count_idle, busy, loaded_count_r == '0, "load count kept during output")

endmodule
`default_nettype wire
